[sv/sha256h_pkg.sv]
package sha256h_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS    = 64;
    localparam int unsigned ROUND_W   = $clog2(ROUNDS);
    localparam int unsigned FILL_W    = 6;
    localparam int unsigned COUNT_W   = 61;
    localparam int unsigned IDX_W     = 3;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [FILL_W-1:0] LEN_POS   = FILL_W'(56);
    localparam logic [FILL_W-1:0] LAST_POS  = FILL_W'(63);
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(7);

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // Per-cycle commands from the sequencer to the datapath
    typedef struct packed {
        logic       byte_we;    // byte enters the block store
        logic       word_done;  // fourth byte of a word
        logic       start;      // load working vars from chaining words
        logic       step;       // one round plus one schedule shift
        logic       fold;       // add working vars into chaining words
        logic       init;       // chaining words back to initial values
    } ctl_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[sv/sha256_byte_stream_hasher_unit.sv]
// SHA-256 over a byte stream. Each input word carries one byte (s_tuser low)
// or a finish marker (s_tuser high). Bytes are packed into a 16-word block
// window; on the 64th byte a single shared round unit runs the 64 rounds,
// one per cycle, then adds the working variables back into the chaining
// words; s_tready is low while a block is compressed (rounds and add-back).
// A finish feeds the padding and 64-bit bit length through the same byte
// path, one byte per cycle; when fill is not below 56 this takes a second
// block of 64 padding bytes, rounds and add-back. Eight output words follow,
// H0 first, the last marked by m_tlast. The hasher then returns to the
// initial chaining values for the next message.
module sha256_byte_stream_hasher_unit
    import sha256h_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] digest_word, [34:32] word_index, zero above
    output logic        m_tlast     // last_word
);

    state_t state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic pad_reg, pad_next;      // finish in progress
    logic first_reg, first_next;  // 0x80 still to go
    logic len_reg, len_next;      // writing the length field
    logic final_reg, final_next;  // running compression is the last one

    ctl_t              ctl;
    logic [7:0]        byte_in;
    logic [7:0]        pad_byte;
    logic [63:0]       bit_len;
    logic [63:0]       len_shift;
    logic              len_now;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] digest_word;

    assign bit_len   = {count_reg, 3'b000};
    assign len_shift = bit_len >> {~fill_reg[2:0], 3'b000};
    assign len_now   = !first_reg && (len_reg || fill_reg == LEN_POS);

    always_comb begin
        if (first_reg) begin
            pad_byte = PAD_BYTE;
        end else if (len_now) begin
            pad_byte = len_shift[7:0];
        end else begin
            pad_byte = 8'h00;
        end
    end

    assign byte_in = (state_reg == ST_PAD) ? pad_byte : s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            count_reg <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            pad_reg   <= 1'b0;
            first_reg <= 1'b0;
            len_reg   <= 1'b0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            pad_reg   <= pad_next;
            first_reg <= first_next;
            len_reg   <= len_next;
            final_reg <= final_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        pad_next   = pad_reg;
        first_next = first_reg;
        len_next   = len_reg;
        final_next = final_reg;
        ctl        = '0;
        ctl.word_done = (fill_reg[1:0] == 2'b11);
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == KIND_DATA) begin
                        ctl.byte_we = 1'b1;
                        fill_next   = fill_reg + 1'b1;
                        count_next  = count_reg + 1'b1;
                        if (fill_reg == LAST_POS) begin
                            ctl.start  = 1'b1;
                            round_next = '0;
                            final_next = 1'b0;
                            state_next = ST_ROUND;
                        end
                    end else begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                        len_next   = 1'b0;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                ctl.byte_we = 1'b1;
                fill_next   = fill_reg + 1'b1;
                first_next  = 1'b0;
                if (len_now) begin
                    len_next = 1'b1;
                end
                if (fill_reg == LAST_POS) begin
                    ctl.start  = 1'b1;
                    round_next = '0;
                    final_next = len_now;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                ctl.step   = 1'b1;
                round_next = round_reg + 1'b1;
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                ctl.fold = 1'b1;
                if (final_reg) begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end else if (pad_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == LAST_IDX) begin
                        ctl.init   = 1'b1;
                        count_next = '0;
                        fill_next  = '0;
                        pad_next   = 1'b0;
                        len_next   = 1'b0;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    sha256h_sched u_sched (
        .aclk    (aclk),
        .ctl     (ctl),
        .byte_in (byte_in),
        .w_out   (w)
    );

    sha256h_round u_round (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .round       (round_reg),
        .w_in        (w),
        .idx         (idx_reg),
        .digest_word (digest_word)
    );

    assign m_tdata = {5'b00000, idx_reg, digest_word};
    assign m_tlast = (idx_reg == LAST_IDX);

    // a compression only starts on a full block, so the fill wraps to zero
    a_start_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |=> fill_reg == '0)
        else $error("compression started on a partial block");

    a_fold_round: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.fold |-> round_reg == '0)
        else $error("add-back before all rounds done");

    a_emit_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> fill_reg == '0 && len_reg)
        else $error("digest out before length field written");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && count_reg == '0)
        else $error("not back to initial state after digest");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while digest pending");

endmodule

[sv/sha256h_sched.sv]
module sha256h_sched
    import sha256h_pkg::*;
(
    input  logic              aclk,
    input  ctl_t              ctl,
    input  logic [7:0]        byte_in,
    output logic [WORD_W-1:0] w_out
);

    // 16-word window: holds the block while filling, then slides as the
    // message schedule during the rounds (w_reg[0] is W for this round)
    logic [WORD_W-1:0] w_reg [BLOCK_WORDS];
    logic [23:0]       acc_reg;
    logic [WORD_W-1:0] w_new;

    always_comb begin
        if (ctl.step) begin
            w_new = w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9]
                  + small_sigma1(w_reg[14]);
        end else begin
            w_new = {acc_reg, byte_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.byte_we) begin
            acc_reg <= {acc_reg[15:0], byte_in};
        end
        if (ctl.step || (ctl.byte_we && ctl.word_done)) begin
            for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
                w_reg[k] <= w_reg[k+1];
            end
            w_reg[BLOCK_WORDS-1] <= w_new;
        end
    end

    assign w_out = w_reg[0];

endmodule

[sv/sha256h_round.sv]
module sha256h_round
    import sha256h_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  ctl_t               ctl,
    input  logic [ROUND_W-1:0] round,
    input  logic [WORD_W-1:0]  w_in,
    input  logic [IDX_W-1:0]   idx,
    output logic [WORD_W-1:0]  digest_word
);

    logic [WORD_W-1:0] h_reg [8];
    logic [WORD_W-1:0] v_reg [8];   // a..h
    logic [WORD_W-1:0] t1;
    logic [WORD_W-1:0] t2;

    always_comb begin
        t1 = v_reg[7] + big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + ROUND_K[round] + w_in;
        t2 = big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            v_reg <= h_reg;
        end else if (ctl.step) begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.init) begin
            h_reg <= H_INIT;
        end else if (ctl.fold) begin
            for (int k = 0; k < 8; k++) begin
                h_reg[k] <= h_reg[k] + v_reg[k];
            end
        end
    end

    assign digest_word = h_reg[idx];

endmodule
